/* hw/rtl/tcf_pkg.sv */
// Shared types, constants and the arctangent table for the tilt complementary filter.
// Used by tcf_ctrl, tcf_datapath and tilt_complementary_filter; no dependencies.
package tcf_pkg;

  localparam int ANGLE_FRAC_BITS_DEF   = 28;
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ITER_W                = 5;   // counts up to 24 steps
  localparam int SQRT_STEPS            = 24;  // 48-bit radicand, two bits a step
  localparam int TAB_FRAC              = 28;
  localparam logic [14:0] ACCEL_Z_MIN_RST = 15'd410;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_INTEG,
    ST_SQRT,
    ST_CINIT,
    ST_CORDIC,
    ST_BMUL,
    ST_BADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              capture;
    logic              mul;
    logic              integ;
    logic              sqrt_step;
    logic              cinit;
    logic              cordic_step;
    logic              bmul;
    logic              badd;
    logic              out_load;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic corr_needed;
    logic out_free;
  } status_t;

  // atan(2^-i) in Q.28 radians
  function automatic logic signed [31:0] atan_q28(input logic [ITER_W-1:0] i);
    logic signed [31:0] v;
    begin
      case (i)
        5'd0:    v = 32'sd210828714;
        5'd1:    v = 32'sd124459457;
        5'd2:    v = 32'sd65760959;
        5'd3:    v = 32'sd33381290;
        5'd4:    v = 32'sd16755422;
        5'd5:    v = 32'sd8385879;
        5'd6:    v = 32'sd4193963;
        5'd7:    v = 32'sd2097109;
        5'd8:    v = 32'sd1048571;
        5'd9:    v = 32'sd524287;
        5'd10:   v = 32'sd262144;
        5'd11:   v = 32'sd131072;
        5'd12:   v = 32'sd65536;
        5'd13:   v = 32'sd32768;
        5'd14:   v = 32'sd16384;
        5'd15:   v = 32'sd8192;
        5'd16:   v = 32'sd4096;
        5'd17:   v = 32'sd2048;
        5'd18:   v = 32'sd1024;
        5'd19:   v = 32'sd512;
        5'd20:   v = 32'sd256;
        5'd21:   v = 32'sd128;
        5'd22:   v = 32'sd64;
        5'd23:   v = 32'sd32;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* hw/rtl/tcf_ctrl.sv */
// Sequencer of the tilt complementary filter: steps the datapath through one word.
// Depends on tcf_pkg.
module tcf_ctrl #(
  parameter int CORDIC_ITERATIONS = tcf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  tcf_pkg::status_t status,
  output tcf_pkg::cmd_t    cmd
);
  import tcf_pkg::*;

  localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQRT_STEPS - 1);
  localparam logic [ITER_W-1:0] CORD_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_INTEG;
      ST_INTEG: begin
        cnt_nxt   = '0;
        state_nxt = status.corr_needed ? ST_SQRT : ST_DONE;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) state_nxt = ST_CINIT;
      end
      ST_CINIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CORD_LAST) state_nxt = ST_BMUL;
      end
      ST_BMUL:   state_nxt = ST_BADD;
      ST_BADD:   state_nxt = ST_DONE;
      ST_DONE:   if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.iter  = cnt_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_MUL:    cmd.mul         = 1'b1;
      ST_INTEG:  cmd.integ       = 1'b1;
      ST_SQRT:   cmd.sqrt_step   = 1'b1;
      ST_CINIT:  cmd.cinit       = 1'b1;
      ST_CORDIC: cmd.cordic_step = 1'b1;
      ST_BMUL:   cmd.bmul        = 1'b1;
      ST_BADD:   cmd.badd        = 1'b1;
      ST_DONE:   cmd.out_load    = status.out_free;
      default:   cmd.iter        = cnt_r;
    endcase
  end

endmodule

/* hw/rtl/tcf_datapath.sv */
// Datapath of the tilt complementary filter: angle state, integration, square root,
// two CORDIC lanes, blend and the output register. Depends on tcf_pkg.
module tcf_datapath #(
  parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcf_pkg::cmd_t    cmd,
  output tcf_pkg::status_t status,
  input  logic [111:0]     in_tdata,
  input  logic [14:0]      accel_z_min,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic [1:0]       out_tuser
);
  import tcf_pkg::*;

  localparam int SH     = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int OUT_SH = ANGLE_FRAC_BITS - 13;
  localparam logic signed [34:0] LIM = 35'sd4 <<< ANGLE_FRAC_BITS;

  function automatic logic signed [31:0] clamp(input logic signed [34:0] v);
    logic signed [34:0] r;
    begin
      r = v;
      if (v > LIM) r = LIM;
      if (v < -LIM) r = -LIM;
      return r[31:0];
    end
  endfunction

  function automatic logic [15:0] to_out(input logic signed [31:0] a);
    logic signed [31:0] v;
    logic [15:0]        r;
    begin
      v = a >>> OUT_SH;
      r = v[15:0];
      if (v > 32'sd32767) r = 16'h7fff;
      if (v < -32'sd32768) r = 16'h8000;
      return r;
    end
  endfunction

  // sample word
  logic [15:0]        idx_r, dt_r;
  logic signed [15:0] gx_r, gy_r, ax_r, ay_r, az_r;
  logic [15:0]        last_idx_r;
  logic               seen_r, integ_r, corr_r;
  logic signed [31:0] pitch_r, roll_r;
  logic signed [32:0] gp_r, gr_r;
  logic [30:0]        sqy_r, sqz_r;
  // square root
  logic [47:0]        rad_r;
  logic [26:0]        rem_r;
  logic [23:0]        root_r;
  // CORDIC lanes
  logic signed [27:0] px_r, py_r, rx_r, ry_r;
  logic signed [31:0] pz_r, rz_r;
  // blend
  logic signed [49:0] bp_r, br_r;
  // output
  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic [1:0]         out_user_r;

  logic [26:0]        rem_t, trial;
  logic [31:0]        sq_sum;
  logic signed [31:0] atan_i;
  logic signed [31:0] tp, tr;
  logic signed [32:0] dp, dr;
  logic signed [16:0] dt_s;

  assign status.corr_needed = corr_r;
  assign status.out_free    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign rem_t  = {rem_r[24:0], rad_r[47:46]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign sq_sum = 32'(sqy_r) + 32'(sqz_r);
  assign atan_i = atan_q28(cmd.iter);
  assign tp     = pz_r >>> SH;
  assign tr     = -(rz_r >>> SH);
  assign dp     = 33'(tp) - 33'(pitch_r);
  assign dr     = 33'(tr) - 33'(roll_r);
  assign dt_s   = $signed({1'b0, dt_r});

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r  <= '0;
      seen_r      <= 1'b0;
      pitch_r     <= '0;
      roll_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.integ && integ_r) begin
        last_idx_r <= idx_r;
        seen_r     <= 1'b1;
        pitch_r    <= clamp(35'(pitch_r) + 35'(gp_r >>> SH));
        roll_r     <= clamp(35'(roll_r) + 35'(gr_r >>> SH));
      end
      if (cmd.badd) begin
        pitch_r <= clamp(35'(pitch_r) + 35'(bp_r >>> 16));
        roll_r  <= clamp(35'(roll_r) + 35'(br_r >>> 16));
      end
      if (cmd.out_load)   out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r  <= in_tdata[15:0];
      gx_r   <= $signed(in_tdata[31:16]);
      gy_r   <= $signed(in_tdata[47:32]);
      ax_r   <= $signed(in_tdata[63:48]);
      ay_r   <= $signed(in_tdata[79:64]);
      az_r   <= $signed(in_tdata[95:80]);
      dt_r   <= in_tdata[111:96];
      corr_r <= $signed(in_tdata[95:80]) > $signed({1'b0, accel_z_min});
    end
    if (cmd.mul) begin
      integ_r <= !seen_r || (idx_r != last_idx_r);
      gp_r    <= gx_r * dt_s;
      gr_r    <= gy_r * dt_s;
      sqy_r   <= 31'(ay_r * ay_r);
      sqz_r   <= 31'(az_r * az_r);
    end
    if (cmd.integ) begin
      rad_r  <= {sq_sum, 16'h0000};
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[45:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= rem_t - trial;
        root_r <= {root_r[22:0], 1'b1};
      end else begin
        rem_r  <= rem_t;
        root_r <= {root_r[22:0], 1'b0};
      end
    end
    if (cmd.cinit) begin
      px_r <= 28'($signed({az_r, 8'h00}));
      py_r <= 28'($signed({ay_r, 8'h00}));
      rx_r <= $signed({4'b0000, root_r});
      ry_r <= 28'($signed({ax_r, 8'h00}));
      pz_r <= '0;
      rz_r <= '0;
    end
    if (cmd.cordic_step) begin
      if (!py_r[27]) begin
        px_r <= px_r + (py_r >>> cmd.iter);
        py_r <= py_r - (px_r >>> cmd.iter);
        pz_r <= pz_r + atan_i;
      end else begin
        px_r <= px_r - (py_r >>> cmd.iter);
        py_r <= py_r + (px_r >>> cmd.iter);
        pz_r <= pz_r - atan_i;
      end
      if (!ry_r[27]) begin
        rx_r <= rx_r + (ry_r >>> cmd.iter);
        ry_r <= ry_r - (rx_r >>> cmd.iter);
        rz_r <= rz_r + atan_i;
      end else begin
        rx_r <= rx_r - (ry_r >>> cmd.iter);
        ry_r <= ry_r + (rx_r >>> cmd.iter);
        rz_r <= rz_r - atan_i;
      end
    end
    if (cmd.bmul) begin
      bp_r <= dp * dt_s;
      br_r <= dr * dt_s;
    end
    if (cmd.out_load) begin
      out_data_r <= {to_out(roll_r), to_out(pitch_r)};
      out_user_r <= {corr_r, integ_r};
    end
  end

endmodule

/* hw/rtl/tilt_complementary_filter.sv */
// Tilt complementary filter: pitch and roll from gyro integration and accelerometer tilt.
// Without tilt correction a word is captured, multiplied, integrated and loaded out; with
// it, a 24-step square root, both CORDIC lanes in step and the blend follow; output may stall.
// The sequencer takes one word at a time; a new word enters once the last is in the output reg.
// Reset (rst_n, synchronous, active low): angles and sample history clear, threshold to 410.
// Depends on tcf_pkg, tcf_ctrl and tcf_datapath.
module tilt_complementary_filter #(
  parameter int ANGLE_FRAC_BITS   = tcf_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_ITERATIONS = tcf_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // sample words
  input  logic         in_tvalid,
  output logic         in_tready,
  // sample_index, gyro_x, gyro_y, accel_x, accel_y, accel_z, dt_step (16 bits each, low up)
  input  logic [111:0] in_tdata,
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  // pitch_out [15:0], roll_out [31:16]
  output logic [31:0]  out_tdata,
  // integrated [0], corrected [1]
  output logic [1:0]   out_tuser,
  // threshold register accel_z_min
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [14:0]  cfg_data
);
  import tcf_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [14:0] accel_z_min_r;

  // Always take the register write; the threshold is compared when a word is captured.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_z_min_r <= ACCEL_Z_MIN_RST;
    end else if (cfg_valid) begin
      accel_z_min_r <= cfg_data;
    end
  end

  // Sequencer: capture, multiply, integrate, then root, CORDIC and blend when corrected.
  tcf_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and the output register; the result waits there while the next word enters.
  tcf_datapath #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .accel_z_min(accel_z_min_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
